// ----- hw/rtl/evw_pkg.sv -----
// ----------------------------------------------------------------------------
// evw_pkg: shared types, constants and sine table for the envelope wah
// Holds the sequencer states, mode and register codes, fixed-point constants
// and the quarter-wave sine table that is built at elaboration.
// ----------------------------------------------------------------------------
package evw_pkg;

  // sine table geometry
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned SINE_LEN        = 1 << SINE_TABLE_BITS;
  localparam int unsigned QUARTER         = SINE_LEN / 4;
  localparam int unsigned QIDX_W          = SINE_TABLE_BITS - 1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;

  // port widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned SAMPLE_W   = 16;

  // serial multiplier geometry
  localparam int unsigned MUL_A_W = 36;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned CNT_W   = 6;
  localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MUL_B_W);

  // fixed-point constants
  localparam logic [12:0] ATTACK_Q16   = 13'd655;
  localparam logic [12:0] RELEASE_Q16  = 13'd6554;
  localparam logic [10:0] SMOOTH_Q20   = 11'd1049;
  localparam logic [23:0] FREQ_MIN_Q10 = 24'd51200;
  localparam logic [23:0] FREQ_MAX_Q10 = 24'd10240000;
  localparam logic [23:0] FREQ_RST_Q10 = 24'd512000;
  localparam logic [23:0] FORMANT1_Q10 = 24'd716800;
  localparam logic [18:0] FORMANT_SPAN = 19'd512000;
  localparam logic [23:0] ENV_ONE      = 24'd8388608;

  // register reset values
  localparam logic [12:0] LOW_RST   = 13'd200;
  localparam logic [13:0] HIGH_RST  = 14'd3000;
  localparam logic [15:0] DAMP_RST  = 16'd3277;
  localparam logic [15:0] PEDAL_RST = 16'd32768;
  localparam logic [23:0] LSTEP_RST = 24'd357914;
  localparam logic [19:0] HZ_RST    = 20'd89478;

  typedef enum logic [1:0] {
    MODE_AUTO,
    MODE_LFO,
    MODE_PEDAL,
    MODE_TALK
  } wah_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_LOW,
    REG_HIGH,
    REG_DAMP,
    REG_PEDAL,
    REG_LSTEP,
    REG_HZ
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_ENV,
    S_ENV_DONE,
    S_TGT,
    S_SMOOTH_SET,
    S_SMOOTH,
    S_ARG_SET,
    S_ARG,
    S_RD_A,
    S_RD_B,
    S_RD_D,
    S_INTERP,
    S_LP_SET,
    S_LP,
    S_DMP_SET,
    S_DMP,
    S_HP_SET,
    S_HP,
    S_OUT
  } evw_state_e;

  typedef logic [30:0] qtab_t [QUARTER+1];

  // sin(x) for x in [0, pi/2], Q30 in and out, taylor form
  function automatic logic [30:0] quarter_sin(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    if (s > Q30_ONE) s = Q30_ONE;
    return s[30:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int unsigned k = 0; k <= QUARTER; k++) begin
      tab[k] = quarter_sin((HALF_PI_Q30 * k) >> (SINE_TABLE_BITS - 2));
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // full-period entry from the quarter table, Q30 signed
  function automatic logic signed [31:0] sine_entry(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]        quad;
    logic [QIDX_W-1:0] r;
    logic [QIDX_W-1:0] k;
    logic signed [31:0] v;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    r    = {1'b0, idx[SINE_TABLE_BITS-3:0]};
    k    = quad[0] ? (QIDX_W'(QUARTER) - r) : r;
    v    = $signed({1'b0, QTAB[k]});
    return quad[1] ? -v : v;
  endfunction

  // sign-magnitude to two's complement
  function automatic logic signed [39:0] apply_sign(input logic [38:0] mag, input logic neg);
    logic signed [39:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sh007FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -40'sh0080000000) return -32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ----- hw/rtl/envelope_wah_filter.sv -----
// ----------------------------------------------------------------------------
// envelope_wah_filter: envelope / lfo / pedal / formant wah on a state-variable
// Target frequency, smoothing, sine coefficient and the filter update all run
// through one shared bit-serial shift-add multiplier under a sequencer.
// ----------------------------------------------------------------------------
// multiplier: every product runs through the one-bit-per-cycle multiplier
// items: a new item is taken only in idle, after the last result has been
//   registered; the last step stalls while a result waits
// reset: registers and filter state return to their reset values at once
// ----------------------------------------------------------------------------
module envelope_wah_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [evw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [evw_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input items
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [evw_pkg::SAMPLE_W-1:0]    s_axis_tdata,  // [15:0] sample_in
  // result items
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [evw_pkg::SAMPLE_W-1:0]    m_axis_tdata   // [15:0] sample_out
);
  import evw_pkg::*;

  // configuration registers
  wah_mode_e   mode_q;
  logic [12:0] low_q;
  logic [13:0] high_q;
  logic [15:0] damp_q;
  logic [15:0] pedal_q;
  logic [23:0] lstep_q;
  logic [19:0] hz_q;

  evw_state_e state_q, state_d;

  // model state
  logic [23:0]        env_q, env_d;
  logic [31:0]        phase_q, phase_d;
  logic [23:0]        fq_q, fq_d;
  logic signed [31:0] lp_q, lp_d;
  logic signed [31:0] bp_q, bp_d;

  // working registers
  logic signed [15:0] x_q, x_d;
  logic               env_dn_q, env_dn_d;
  logic [31:0]        lk_ph_q, lk_ph_d;
  logic               lk_coef_q, lk_coef_d;
  logic signed [31:0] tab_a_q, tab_a_d;
  logic signed [31:0] rom_q;
  logic [SINE_TABLE_BITS-1:0] rom_addr;
  logic signed [35:0] tgt_q, tgt_d;
  logic               d_neg_q, d_neg_d;
  logic signed [32:0] f_q, f_d;
  logic signed [31:0] hp_q, hp_d;
  logic               mneg_q, mneg_d;
  logic [15:0]        out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // serial multiplier
  logic [MUL_A_W-1:0] ma_q, ma_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               mul_ld;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [MUL_A_W:0]   mul_sum;

  // derived values
  logic [15:0]        abs_x;
  logic [23:0]        level;
  logic               env_up;
  logic [23:0]        env_mag;
  logic signed [14:0] span_hz;
  logic signed [14:0] span_abs;
  logic               span_neg;
  logic [23:0]        span_mag;
  logic [29:0]        env50;
  logic [28:0]        env30;
  logic [23:0]        blend;
  logic [38:0]        tgt_mag;
  logic signed [39:0] tgt_sum;
  logic [23:0]        tgt_base;
  logic signed [35:0] dsub;
  logic [35:0]        dmag;
  logic [26:0]        mv;
  logic signed [37:0] fq_new;
  logic signed [32:0] tdiff;
  logic [32:0]        tdiff_mag;
  logic signed [39:0] sine_val;
  logic [39:0]        lfo_sum;
  logic signed [32:0] f_abs;
  logic signed [31:0] bp_abs;
  logic signed [31:0] hp_abs;
  logic signed [39:0] acc_sum;
  logic signed [31:0] bp_adj;
  logic signed [31:0] y_div;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign mul_done      = (cnt_q == MUL_STEPS);

  // operand conditioning shared by several steps
  always_comb begin
    abs_x    = x_q[15] ? 16'(-x_q) : x_q;
    level    = {abs_x, 8'b0};
    env_up   = (level > env_q);
    env_mag  = env_up ? (level - env_q) : (env_q - level);
    span_hz  = $signed({1'b0, high_q}) - $signed({2'b0, low_q});
    span_neg = span_hz[14];
    span_abs = span_neg ? -span_hz : span_hz;
    span_mag = {span_abs[13:0], 10'b0};
    env50    = {1'b0, env_q, 5'b0} + {2'b0, env_q, 4'b0} + {5'b0, env_q, 1'b0};
    env30    = {env_q, 5'b0} - {3'b0, env_q, 1'b0};
    blend    = (env30 > {5'b0, ENV_ONE}) ? ENV_ONE : env30[23:0];
    f_abs    = f_q[32] ? -f_q : f_q;
    bp_abs   = bp_q[31] ? -bp_q : bp_q;
    hp_abs   = hp_q[31] ? -hp_q : hp_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) state_d = S_START;
      end
      S_START: begin
        case (mode_q)
          MODE_LFO:   state_d = S_RD_A;
          MODE_PEDAL: state_d = S_TGT;
          default:    state_d = S_ENV;
        endcase
      end
      S_ENV:        if (mul_done) state_d = S_ENV_DONE;
      S_ENV_DONE:   state_d = S_TGT;
      S_TGT:        if (mul_done) state_d = S_SMOOTH_SET;
      S_SMOOTH_SET: state_d = S_SMOOTH;
      S_SMOOTH:     if (mul_done) state_d = S_ARG_SET;
      S_ARG_SET:    state_d = S_ARG;
      S_ARG:        if (mul_done) state_d = S_RD_A;
      S_RD_A:       state_d = S_RD_B;
      S_RD_B:       state_d = S_RD_D;
      S_RD_D:       state_d = S_INTERP;
      S_INTERP: begin
        if (mul_done) state_d = lk_coef_q ? S_LP_SET : S_TGT;
      end
      S_LP_SET:     state_d = S_LP;
      S_LP:         if (mul_done) state_d = S_DMP_SET;
      S_DMP_SET:    state_d = S_DMP;
      S_DMP:        if (mul_done) state_d = S_HP_SET;
      S_HP_SET:     state_d = S_HP;
      S_HP:         if (mul_done) state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
      end
      default:      state_d = S_IDLE;
    endcase
  end

  // datapath and multiplier control
  always_comb begin
    x_d         = x_q;
    env_d       = env_q;
    env_dn_d    = env_dn_q;
    phase_d     = phase_q;
    fq_d        = fq_q;
    lp_d        = lp_q;
    bp_d        = bp_q;
    lk_ph_d     = lk_ph_q;
    lk_coef_d   = lk_coef_q;
    tab_a_d     = tab_a_q;
    tgt_d       = tgt_q;
    d_neg_d     = d_neg_q;
    f_d         = f_q;
    hp_d        = hp_q;
    mneg_d      = mneg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mul_ld      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    rom_addr    = lk_ph_q[31 -: SINE_TABLE_BITS];
    tgt_mag     = '0;
    tgt_sum     = '0;
    tgt_base    = {1'b0, low_q, 10'b0};
    dsub        = tgt_q - $signed({12'b0, fq_q});
    dmag        = dsub[35] ? 36'(-dsub) : 36'(dsub);
    mv          = 27'((prod_q[46:0] + 47'd524288) >> 20);
    fq_new      = '0;
    tdiff       = $signed({rom_q[31], rom_q}) - $signed({tab_a_q[31], tab_a_q});
    tdiff_mag   = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
    sine_val    = $signed({{8{tab_a_q[31]}}, tab_a_q})
                  + apply_sign(prod_q[54:16], mneg_q);
    lfo_sum     = 40'(sine_val) + 40'(Q30_ONE);
    acc_sum     = '0;
    bp_adj      = bp_q + (bp_q[31] ? 32'sd31 : 32'sd0);
    y_div       = bp_adj >>> 5;

    // result register drains on the output handshake
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) x_d = $signed(s_axis_tdata);
      end
      // envelope step, lfo advance or pedal product
      S_START: begin
        case (mode_q)
          MODE_LFO: begin
            phase_d   = phase_q + {8'b0, lstep_q};
            lk_ph_d   = phase_q + {8'b0, lstep_q};
            lk_coef_d = 1'b0;
          end
          MODE_PEDAL: begin
            mul_ld = 1'b1;
            mul_a  = MUL_A_W'(span_mag);
            mul_b  = MUL_B_W'(pedal_q);
            mneg_d = span_neg;
          end
          default: begin
            mul_ld   = 1'b1;
            mul_a    = MUL_A_W'(env_mag);
            mul_b    = MUL_B_W'(env_up ? ATTACK_Q16 : RELEASE_Q16);
            env_dn_d = (level < env_q);
          end
        endcase
      end
      S_ENV: begin
        if (mul_done) begin
          env_d = env_dn_q ? (env_q - prod_q[39:16]) : (env_q + prod_q[39:16]);
        end
      end
      // span times envelope, or formant blend
      S_ENV_DONE: begin
        mul_ld = 1'b1;
        if (mode_q == MODE_AUTO) begin
          mul_a  = MUL_A_W'(span_mag);
          mul_b  = MUL_B_W'(env50);
          mneg_d = span_neg;
        end else begin
          mul_a  = MUL_A_W'(FORMANT_SPAN);
          mul_b  = MUL_B_W'(blend);
          mneg_d = 1'b0;
        end
      end
      S_TGT: begin
        if (mul_done) begin
          case (mode_q)
            MODE_LFO:   tgt_mag = {1'b0, prod_q[67:30]};
            MODE_PEDAL: tgt_mag = prod_q[54:16];
            default:    tgt_mag = prod_q[61:23];
          endcase
          if (mode_q == MODE_TALK) tgt_base = FORMANT1_Q10;
          tgt_sum = $signed({16'b0, tgt_base}) + apply_sign(tgt_mag, mneg_q);
          tgt_d   = 36'(tgt_sum);
        end
      end
      // smoothing toward the target
      S_SMOOTH_SET: begin
        mul_ld  = 1'b1;
        mul_a   = dmag;
        mul_b   = MUL_B_W'(SMOOTH_Q20);
        d_neg_d = dsub[35];
      end
      S_SMOOTH: begin
        if (mul_done) begin
          fq_new = d_neg_q ? ($signed({14'b0, fq_q}) - $signed({11'b0, mv}))
                           : ($signed({14'b0, fq_q}) + $signed({11'b0, mv}));
          if (fq_new < $signed({14'b0, FREQ_MIN_Q10})) fq_d = FREQ_MIN_Q10;
          else if (fq_new > $signed({14'b0, FREQ_MAX_Q10})) fq_d = FREQ_MAX_Q10;
          else fq_d = fq_new[23:0];
        end
      end
      // phase argument of the filter coefficient
      S_ARG_SET: begin
        mul_ld = 1'b1;
        mul_a  = MUL_A_W'(fq_q);
        mul_b  = MUL_B_W'(hz_q);
      end
      S_ARG: begin
        if (mul_done) begin
          lk_ph_d   = prod_q[42:11];
          lk_coef_d = 1'b1;
        end
      end
      // table reads for interpolation
      S_RD_A: begin
        rom_addr = lk_ph_q[31 -: SINE_TABLE_BITS];
      end
      S_RD_B: begin
        tab_a_d  = rom_q;
        rom_addr = lk_ph_q[31 -: SINE_TABLE_BITS] + 1'b1;
      end
      S_RD_D: begin
        mul_ld = 1'b1;
        mul_a  = MUL_A_W'(tdiff_mag[31:0]);
        mul_b  = MUL_B_W'(lk_ph_q[31-SINE_TABLE_BITS -: 16]);
        mneg_d = tdiff[32];
      end
      S_INTERP: begin
        if (mul_done) begin
          if (lk_coef_q) begin
            f_d = {sine_val[31:0], 1'b0};
          end else begin
            mul_ld = 1'b1;
            mul_a  = MUL_A_W'(span_mag);
            mul_b  = MUL_B_W'(lfo_sum[31:1]);
            mneg_d = span_neg;
          end
        end
      end
      // filter update
      S_LP_SET: begin
        mul_ld = 1'b1;
        mul_a  = MUL_A_W'(f_abs[31:0]);
        mul_b  = bp_abs;
        mneg_d = f_q[32] ^ bp_q[31];
      end
      S_LP: begin
        if (mul_done) begin
          acc_sum = $signed({{8{lp_q[31]}}, lp_q})
                    + apply_sign({1'b0, prod_q[67:30]}, mneg_q);
          lp_d    = sat32(acc_sum);
        end
      end
      S_DMP_SET: begin
        mul_ld = 1'b1;
        mul_a  = MUL_A_W'(damp_q);
        mul_b  = bp_abs;
        mneg_d = bp_q[31];
      end
      S_DMP: begin
        if (mul_done) begin
          acc_sum = $signed({{19{x_q[15]}}, x_q, 5'b0})
                    - $signed({{8{lp_q[31]}}, lp_q})
                    - apply_sign(prod_q[52:14], mneg_q);
          hp_d    = sat32(acc_sum);
        end
      end
      S_HP_SET: begin
        mul_ld = 1'b1;
        mul_a  = MUL_A_W'(f_abs[31:0]);
        mul_b  = hp_abs;
        mneg_d = f_q[32] ^ hp_q[31];
      end
      S_HP: begin
        if (mul_done) begin
          acc_sum = $signed({{8{bp_q[31]}}, bp_q})
                    + apply_sign({1'b0, prod_q[67:30]}, mneg_q);
          bp_d    = sat32(acc_sum);
        end
      end
      // saturated output into the result register
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (y_div > 32'sd32767) out_d = 16'h7FFF;
          else if (y_div < -32'sd32768) out_d = 16'h8000;
          else out_d = y_div[15:0];
        end
      end
      default: ;
    endcase
  end

  // shift-add step, one multiplier bit per cycle
  always_comb begin
    mul_sum = {1'b0, prod_q[PROD_W-1:MUL_B_W]} + {1'b0, (prod_q[0] ? ma_q : '0)};
    ma_d    = ma_q;
    prod_d  = prod_q;
    cnt_d   = cnt_q;
    if (mul_ld) begin
      ma_d   = mul_a;
      prod_d = {{MUL_A_W{1'b0}}, mul_b};
      cnt_d  = '0;
    end else if (!mul_done) begin
      prod_d = {mul_sum, prod_q[MUL_B_W-1:1]};
      cnt_d  = cnt_q + 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_AUTO;
      low_q   <= LOW_RST;
      high_q  <= HIGH_RST;
      damp_q  <= DAMP_RST;
      pedal_q <= PEDAL_RST;
      lstep_q <= LSTEP_RST;
      hz_q    <= HZ_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MODE:  mode_q  <= wah_mode_e'(cfg_data_i[1:0]);
        REG_LOW:   low_q   <= cfg_data_i[12:0];
        REG_HIGH:  high_q  <= cfg_data_i[13:0];
        REG_DAMP:  damp_q  <= cfg_data_i[15:0];
        REG_PEDAL: pedal_q <= cfg_data_i[15:0];
        REG_LSTEP: lstep_q <= cfg_data_i[23:0];
        REG_HZ:    hz_q    <= cfg_data_i[19:0];
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= MUL_STEPS;
      env_q       <= '0;
      phase_q     <= '0;
      fq_q        <= FREQ_RST_Q10;
      lp_q        <= '0;
      bp_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      env_q       <= env_d;
      phase_q     <= phase_d;
      fq_q        <= fq_d;
      lp_q        <= lp_d;
      bp_q        <= bp_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    env_dn_q  <= env_dn_d;
    lk_ph_q   <= lk_ph_d;
    lk_coef_q <= lk_coef_d;
    tab_a_q   <= tab_a_d;
    rom_q     <= sine_entry(rom_addr);
    tgt_q     <= tgt_d;
    d_neg_q   <= d_neg_d;
    f_q       <= f_d;
    hp_q      <= hp_d;
    mneg_q    <= mneg_d;
    out_q     <= out_d;
    ma_q      <= ma_d;
    prod_q    <= prod_d;
  end

  // multiplier is only loaded when idle
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_ld |-> mul_done)
    else $error("multiplier loaded while busy");

  // smoothed frequency stays inside its clamp
  a_fq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fq_q >= FREQ_MIN_Q10) && (fq_q <= FREQ_MAX_Q10))
    else $error("centre frequency out of range");

  // finishing an item always presents a result
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && state_d == S_IDLE) |=> out_valid_q)
    else $error("result not presented");

  // no new item while the sequencer is busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("input ready while busy");

endmodule

// ----- bench/tb_envelope_wah_filter.sv -----
// ----------------------------------------------------------------------------
// tb_envelope_wah_filter: self-checking bench for the envelope wah filter
// Drives audio items through the stream ports under random backpressure,
// predicts every bandpass output with a fixed-point model of the sweep
// sources, smoother, sine coefficient and state-variable filter, and walks
// the register file through several settings, extremes included.
// ----------------------------------------------------------------------------
module tb_envelope_wah_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import evw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int unsigned RUN_LIMIT = 3000000;
  localparam longint Q30 = 64'sd1 << 30;
  localparam longint ENV_UNIT = 64'sd1 << 23;

  // bandpass prediction and the queue of expected output samples
  class wah_scoreboard;
    int sine_tab [SINE_LEN];
    wah_mode_e mode;
    bit [12:0] low_hz;
    bit [13:0] high_hz;
    bit [15:0] damp;
    bit [15:0] pedal;
    bit [23:0] lfo_inc;
    bit [19:0] hz_scale;
    longint lp_acc, bp_acc;
    bit [23:0] freq_q10;
    bit [23:0] env_lvl;
    bit [31:0] lfo_ph;
    logic [15:0] out_q [$];
    int errors, results, items;

    function new();
      longint unsigned x, x2, t, s, k;
      int unsigned quad, r;
      for (int unsigned i = 0; i < SINE_LEN; i++) begin
        quad = i >> (SINE_TABLE_BITS - 2);
        r = i & (QUARTER - 1);
        k = (quad & 1) ? QUARTER - r : r;
        x = (64'd1686629713 * k) >> (SINE_TABLE_BITS - 2);
        x2 = (x * x) >> 30;
        t = Q30 - x2 / 110;
        t = Q30 - ((x2 * t) >> 30) / 72;
        t = Q30 - ((x2 * t) >> 30) / 42;
        t = Q30 - ((x2 * t) >> 30) / 20;
        t = Q30 - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        if (s > Q30) s = Q30;
        sine_tab[i] = (quad >= 2) ? -int'(s) : int'(s);
      end
      mode = MODE_AUTO; low_hz = 200; high_hz = 3000; damp = 3277;
      pedal = 32768; lfo_inc = 357914; hz_scale = 89478;
      lp_acc = 0; bp_acc = 0; freq_q10 = 500 * 1024; env_lvl = 0; lfo_ph = 0;
      errors = 0; results = 0; items = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:  mode = wah_mode_e'(data[1:0]);
        REG_LOW:   low_hz = data[12:0];
        REG_HIGH:  high_hz = data[13:0];
        REG_DAMP:  damp = data[15:0];
        REG_PEDAL: pedal = data[15:0];
        REG_LSTEP: lfo_inc = data[23:0];
        REG_HZ:    hz_scale = data[19:0];
        default: ;
      endcase
    endfunction

    function longint sine_at(bit [31:0] ph);
      longint a, b, fr;
      int unsigned i;
      i = ph >> (32 - SINE_TABLE_BITS);
      fr = (ph >> (16 - SINE_TABLE_BITS)) & 32'hFFFF;
      a = sine_tab[i % SINE_LEN];
      b = sine_tab[(i + 1) % SINE_LEN];
      return a + ((b - a) * fr) / 65536;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // attack/release follower on the rectified sample
    function void follow(longint x);
      longint level, env, delta, mag, stp, rate;
      level = (x < 0 ? -x : x) * 256;
      env = env_lvl;
      rate = (level > env) ? 655 : 6554;
      delta = level - env;
      mag = delta < 0 ? -delta : delta;
      stp = (mag * rate) >>> 16;
      env = (delta < 0) ? env - stp : env + stp;
      env_lvl = env[23:0];
    endfunction

    function void note_input(logic [15:0] raw);
      longint x, lo, span, target, fq, d, dm, mv, blend, f, hp, y;
      bit [31:0] arg;
      x = longint'($signed(raw));
      lo = longint'(low_hz) * 1024;
      span = (longint'(high_hz) - longint'(low_hz)) * 1024;
      case (mode)
        MODE_AUTO: begin
          follow(x);
          target = lo + (span * longint'(env_lvl) * 50) / ENV_UNIT;
        end
        MODE_LFO: begin
          lfo_ph = lfo_ph + 32'(lfo_inc);
          target = lo + (span * ((sine_at(lfo_ph) + Q30) / 2)) / Q30;
        end
        MODE_PEDAL: target = lo + (span * longint'(pedal)) / 65536;
        default: begin
          follow(x);
          blend = longint'(env_lvl) * 30;
          if (blend > ENV_UNIT) blend = ENV_UNIT;
          target = 716800 + (64'sd512000 * blend) / ENV_UNIT;
        end
      endcase
      // smoothing toward target, then clamp to the audio band
      fq = freq_q10;
      d = target - fq;
      dm = d < 0 ? -d : d;
      mv = (dm * 1049 + 524288) >>> 20;
      fq = (d < 0) ? fq - mv : fq + mv;
      if (fq < 51200) fq = 51200;
      if (fq > 10240000) fq = 10240000;
      freq_q10 = fq[23:0];
      arg = 32'((longint'(freq_q10) * longint'(hz_scale)) >>> 11);
      f = 2 * sine_at(arg);
      // state-variable filter update
      lp_acc = sat32(lp_acc + (f * bp_acc) / Q30);
      hp = sat32(x * 32 - lp_acc - (longint'(damp) * bp_acc) / 16384);
      bp_acc = sat32(bp_acc + (f * hp) / Q30);
      y = bp_acc / 32;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      out_q.push_back(y[15:0]);
      items++;
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("mismatch %s: result %0d got %0d expected %0d", what, results,
               $signed(got), $signed(want));
    endtask

    task check(logic [15:0] got);
      logic [15:0] want;
      if (out_q.size() == 0) begin
        report("unexpected item", got, 16'd0);
      end else begin
        want = out_q.pop_front();
        if (got !== want) report("sample_out", got, want);
      end
      results++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [SAMPLE_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_axis_tdata;

  wah_scoreboard sb = new();
  bit steady = 1'b0;
  int stall_left = 0;
  int unsigned cycles = 0;
  int phases = 0;

  envelope_wah_filter DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == RUN_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL envelope_wah_filter");
      $finish;
    end
  end

  // receiver backpressure in bursts
  always @(posedge clk_i) begin
    if (steady) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
  end

  // keeps cfg_valid_i high until cfg_done
  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    sb.set_reg(idx, data);
  endtask

  task cfg_done();
    cfg_valid_i <= 1'b0;
  endtask

  task send_sample(logic [15:0] smp);
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_input(smp);
  endtask

  // stop sending and wait for every outstanding result
  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.out_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task write_all(logic [1:0] m, logic [12:0] lo, logic [13:0] hi, logic [15:0] dmp,
                 logic [15:0] ped, logic [23:0] stp, logic [19:0] hz);
    write_reg(REG_MODE, 24'(m));
    write_reg(REG_LOW, 24'(lo));
    write_reg(REG_HIGH, 24'(hi));
    write_reg(REG_DAMP, 24'(dmp));
    write_reg(REG_PEDAL, 24'(ped));
    write_reg(REG_LSTEP, stp);
    write_reg(REG_HZ, 24'(hz));
    cfg_done();
    phases++;
  endtask

  function logic [15:0] pick_sample(int unsigned n);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 16'($urandom);
      4, 5, 6: return (n % 16 < 8) ? 16'($urandom_range(20000, 32767))
                                   : -16'($urandom_range(20000, 32768));
      7, 8: return 16'($urandom_range(0, 512) - 256);
      default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  initial begin
    logic [1:0] m;
    logic [12:0] lo;
    logic [13:0] hi;
    logic [19:0] hz;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, sample extremes in auto mode
    send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'h0000);
    send_sample(16'hFFFF); send_sample(16'h0001); send_sample(16'h5555);
    drain();
    // masked write and an unused index; talking mode
    write_reg(REG_NONE, 24'hFFFFFF);
    write_reg(REG_MODE, 24'hFFFFFF);
    cfg_done();
    send_sample(16'h7FFF); send_sample(16'h7FFF); send_sample(16'hAAAA);
    send_sample(16'h0000);
    drain();
    // lfo at its fastest with all register maxima
    write_all(MODE_LFO, 13'h1FFF, 14'h3FFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 20'hFFFFF);
    send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'h1234);
    send_sample(16'hEDCB);
    drain();
    // pedal, inverted sweep range, zero hz scale, minimum damping
    write_all(MODE_PEDAL, 13'd5000, 14'd150, 16'd0, 16'd0, 24'd0, 20'd0);
    send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'h4000);
    drain();
    // auto with a huge target, coefficient past half the sample rate
    write_all(MODE_AUTO, 13'd0, 14'h3FFF, 16'd819, 16'd65535, 24'd1, 20'd1048575);
    send_sample(16'h7FFF); send_sample(16'h8000); send_sample(16'h7FFF);
    send_sample(16'h0100);
    drain();

    // random phases
    for (int p = 0; p < 12; p++) begin
      m = $urandom_range(0, 3);
      lo = (p % 5 == 0) ? 13'($urandom) : 13'($urandom_range(50, 5000));
      hi = (p % 4 == 3) ? 14'($urandom_range(50, 400)) : 14'($urandom_range(150, 10000));
      case ($urandom_range(0, 5))
        0: hz = 20'($urandom);
        1: hz = $urandom_range(0, 1) ? 20'd1 : 20'hFFFFF;
        default: hz = 20'($urandom_range(80000, 100000));
      endcase
      write_all(m, lo, hi, 16'($urandom_range(819, 32768)), 16'($urandom),
                (p % 3 == 0) ? 24'($urandom) : 24'($urandom_range(0, 2000000)), hz);
      if (p == 11) steady = 1'b1;
      for (int unsigned n = 0; n < 145; n++) begin
        send_sample(pick_sample(n));
        // a mid-phase hold-off until the pipeline is empty
        if (n == 70 && p == 4) begin
          s_axis_tvalid <= 1'b0;
          while (sb.out_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    repeat (300) @(posedge clk_i);
    $display("covered %0d items and %0d results over %0d register settings,", sb.items,
             sb.results, phases);
    $display("all four sweep sources, register extremes and %0d mismatches", sb.errors);
    if (sb.errors == 0 && sb.out_q.size() == 0) begin
      $display("PASS envelope_wah_filter");
    end else begin
      $display("FAIL envelope_wah_filter");
    end
    $finish;
  end

endmodule

// ----- envelope_wah_filter.f -----
hw/rtl/evw_pkg.sv
hw/rtl/envelope_wah_filter.sv
bench/tb_envelope_wah_filter.sv
